FILE: rtl/see_pkg.sv
// ============================================================================
// see_pkg - string escape encoder shared types
// Payload structs, the generator phase enum and the character tables
// used by the encoder top level and its character generator.
// ============================================================================
package see_pkg;

   // output format codes
   localparam logic [1:0] FMT_HEX   = 2'd0;
   localparam logic [1:0] FMT_SQL   = 2'd1;
   localparam logic [1:0] FMT_QUOTE = 2'd2;

   // sql wrapper strings
   localparam int SQL_HEAD_LEN = 21;
   localparam int SQL_TAIL_LEN = 18;
   localparam logic [SQL_HEAD_LEN*8-1:0] SQL_HEAD_STR = {"convert", "_from(decode('"};
   localparam logic [SQL_TAIL_LEN*8-1:0] SQL_TAIL_STR = "', 'hex'), 'UTF8')";

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   // position counter covers the longest segment
   localparam int CNT_W = $clog2(SQL_HEAD_LEN);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       empty_string;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_payload_type;

   // segment of the encoded text being emitted
   typedef enum logic [1:0] {
      PH_HEAD,
      PH_BODY,
      PH_TAIL
   } phase_type;

   // transaction held in the input register
   typedef struct packed {
      logic [1:0] fmt;
      logic [7:0] data_byte;
      logic       head_en;
      logic       body_en;
      logic       tail_en;
   } item_type;

   // generator results for the current position
   typedef struct packed {
      logic [7:0] out_char;
      logic       seg_end;
      logic       final_char;
      phase_type  next_phase;
   } gen_type;

   function automatic logic [7:0] sql_head_char(input logic [CNT_W-1:0] idx);
      logic [CNT_W-1:0] pos;
      pos = CNT_W'(SQL_HEAD_LEN - 1) - idx;
      return SQL_HEAD_STR[pos*8 +: 8];
   endfunction

   function automatic logic [7:0] sql_tail_char(input logic [CNT_W-1:0] idx);
      logic [CNT_W-1:0] pos;
      pos = CNT_W'(SQL_TAIL_LEN - 1) - idx;
      return SQL_TAIL_STR[pos*8 +: 8];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h57 + {4'd0, nib};
      end
      return c;
   endfunction

   // character after the backslash, zero when the byte passes unchanged
   function automatic logic [7:0] escape_code(input logic [7:0] b);
      logic [7:0] e;
      case (b)
         8'h07:   e = "a";
         8'h08:   e = "b";
         8'h0C:   e = "f";
         8'h0A:   e = "n";
         8'h0D:   e = "r";
         8'h09:   e = "t";
         8'h0B:   e = "v";
         8'h5C:   e = CHAR_BACKSLASH;
         8'h22:   e = CHAR_QUOTE;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

FILE: rtl/see_gen.sv
// ============================================================================
// see_gen - encoder character generator
// Picks the character for the current segment and position of the held
// transaction and works out where the sequencer goes next.
// ============================================================================
module see_gen (
   input  see_pkg::item_type             item,
   input  see_pkg::phase_type            phase,
   input  logic [see_pkg::CNT_W-1:0]     cnt,
   output see_pkg::gen_type              gen
);
   import see_pkg::*;

   logic [7:0] esc;
   logic       seg_end;
   logic       final_char;
   phase_type  next_phase;
   logic [7:0] out_char;

   assign esc = escape_code(item.data_byte);

   // end of segment and next phase
   always_comb begin
      seg_end    = 1'b1;
      next_phase = phase;
      final_char = 1'b0;
      case (phase)
         PH_HEAD: begin
            seg_end    = (item.fmt == FMT_SQL) ? (cnt == CNT_W'(SQL_HEAD_LEN - 1)) : 1'b1;
            next_phase = item.body_en ? PH_BODY : PH_TAIL;
            final_char = seg_end && !item.body_en && !item.tail_en;
         end
         PH_BODY: begin
            seg_end    = (item.fmt == FMT_QUOTE && esc == 8'h00) ? 1'b1 :
                         (cnt == CNT_W'(1));
            next_phase = PH_TAIL;
            final_char = seg_end && !item.tail_en;
         end
         PH_TAIL: begin
            seg_end    = (item.fmt == FMT_SQL) ? (cnt == CNT_W'(SQL_TAIL_LEN - 1)) : 1'b1;
            next_phase = PH_TAIL;
            final_char = seg_end;
         end
         default: begin
            seg_end    = 1'b1;
            next_phase = PH_TAIL;
            final_char = 1'b1;
         end
      endcase
   end

   // character at the current position
   always_comb begin
      out_char = CHAR_QUOTE;
      case (phase)
         PH_HEAD: begin
            out_char = (item.fmt == FMT_SQL) ? sql_head_char(cnt) : CHAR_QUOTE;
         end
         PH_BODY: begin
            if (item.fmt == FMT_QUOTE) begin
               if (esc == 8'h00) begin
                  out_char = item.data_byte;
               end else begin
                  out_char = (cnt == '0) ? CHAR_BACKSLASH : esc;
               end
            end else begin
               out_char = (cnt == '0) ? hex_char(item.data_byte[7:4]) :
                                        hex_char(item.data_byte[3:0]);
            end
         end
         PH_TAIL: begin
            out_char = (item.fmt == FMT_SQL) ? sql_tail_char(cnt) : CHAR_QUOTE;
         end
         default: begin
            out_char = CHAR_QUOTE;
         end
      endcase
   end

   assign gen = '{out_char: out_char, seg_end: seg_end, final_char: final_char,
                  next_phase: next_phase};

endmodule

FILE: rtl/string_escape_encoder.sv
// ============================================================================
// string_escape_encoder - hex / sql / quoted string encoder
// Turns a string, one byte per transaction, into hex digits, a sql
// hex-decode expression or a double-quoted escaped string.
// ============================================================================
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------
//   req     | in        | req_valid / req_ready | data_byte, first/last/empty
//   rsp     | out       | rsp_valid / rsp_ready | out_char, out_last
//   csr     | in        | csr_wr_en             | output_format (2 bits)
//
// one output character per cycle while the rsp side does not stall; a
// transaction yields 1 to 41 characters, two per byte for hex digits and
// escapes. the next transaction is taken in the
// cycle its predecessor's last character moves to the output register.
// transactions yielding nothing are dropped at the input in their accept cycle.
// synchronous active-high reset clears valids and sets format to hex.
// a stalled rsp side holds the output register and the sequencer.
module string_escape_encoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  see_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output see_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_wr_data
);
   import see_pkg::*;

   logic [1:0]      fmt_ff;
   logic            item_valid_ff;
   item_type        item_ff;
   item_type        item_in;
   phase_type       phase_ff;
   phase_type       phase_in;
   logic [CNT_W-1:0] cnt_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   gen_type         gen;
   logic            req_fire;
   logic            out_load;
   logic            item_done;
   logic            any_seg;
   logic            wrap_en;
   logic            fmt_ok;

   // format register
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_HEX;
      end else if (csr_wr_en) begin
         fmt_ff <= csr_wr_data;
      end
   end

   // segments present for an incoming transaction
   always_comb begin
      wrap_en           = (fmt_ff == FMT_SQL) || (fmt_ff == FMT_QUOTE);
      fmt_ok            = wrap_en || (fmt_ff == FMT_HEX);
      item_in.fmt       = fmt_ff;
      item_in.data_byte = req_payload.data_byte;
      item_in.head_en   = wrap_en && (req_payload.first_byte || req_payload.empty_string);
      item_in.body_en   = fmt_ok && !req_payload.empty_string;
      item_in.tail_en   = wrap_en && (req_payload.last_byte || req_payload.empty_string);
      any_seg           = item_in.head_en || item_in.body_en || item_in.tail_en;
      phase_in          = item_in.head_en ? PH_HEAD : (item_in.body_en ? PH_BODY : PH_TAIL);
   end

   see_gen u_gen (
      .item  (item_ff),
      .phase (phase_ff),
      .cnt   (cnt_ff),
      .gen   (gen)
   );

   // handshake control
   assign out_load  = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign item_done = out_load && gen.final_char;
   assign req_ready = !item_valid_ff || item_done;
   assign req_fire  = req_valid && req_ready;

   // input register and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_HEAD;
         cnt_ff        <= '0;
      end else if (req_fire) begin
         item_valid_ff <= any_seg;
         phase_ff      <= phase_in;
         cnt_ff        <= '0;
      end else if (item_done) begin
         item_valid_ff <= 1'b0;
      end else if (out_load) begin
         phase_ff <= gen.seg_end ? gen.next_phase : phase_ff;
         cnt_ff   <= gen.seg_end ? '0 : cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.out_char <= gen.out_char;
         rsp_ff.out_last <= gen.final_char;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // sequencer only sits in segments the transaction actually has
   a_head_present : assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && phase_ff == PH_HEAD) |-> item_ff.head_en)
      else $error("sequencer in head segment without a prefix");

   a_tail_present : assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && phase_ff == PH_TAIL) |-> item_ff.tail_en)
      else $error("sequencer in tail segment without a suffix");

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      item_valid_ff |-> (cnt_ff < CNT_W'(SQL_HEAD_LEN)))
      else $error("position counter beyond longest segment");

   a_new_item_start : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (cnt_ff == '0))
      else $error("accepted transaction did not restart the position counter");

   a_last_frees_input : assert property (@(posedge clock) disable iff (reset)
      (item_done && !req_valid) |=> !item_valid_ff)
      else $error("input register still busy after final character");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench - string escape encoder
// Sends byte strings through every output format under bursty input and
// random output stalls. Each encoded character is checked against a local
// predictor of the hex, sql-wrapper and quoted-escape encodings.
// ============================================================================
module testbench;
   import see_pkg::*;

   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_PRINTED    = 40;
   localparam int HOLD_MIN_QUEUE = 20;

   // control characters with a backslash escape
   localparam logic [7:0] CHAR_BEL = 8'h07;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_FF  = 8'h0C;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_VT  = 8'h0B;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en = 1'b0;
   logic [1:0]      csr_wr_data = FMT_HEX;

   req_payload_type pending_reqs[$];
   rsp_payload_type expected_chars[$];
   logic [1:0]      predicted_format = FMT_HEX;

   string sql_open  = {string'("convert"), "_from(decode('"};
   string sql_close = "', 'hex'), 'UTF8')";

   logic [7:0] escape_bytes[9] = '{CHAR_BEL, CHAR_BS, CHAR_FF, CHAR_LF, CHAR_CR,
                                   CHAR_TAB, CHAR_VT, CHAR_BACKSLASH, CHAR_QUOTE};
   logic [1:0] phase_formats[9] = '{FMT_SQL, FMT_QUOTE, FMT_HEX, FMT_QUOTE, FMT_UNUSED,
                                    FMT_SQL, FMT_HEX, FMT_QUOTE, FMT_SQL};

   int error_count  = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int burst_left   = 0;
   int gap_left     = 0;
   int hold_left    = 0;
   int holds_done   = 0;
   int next_hold_at = 300;
   int pattern_age  = 0;
   logic [31:0] stall_pattern = '1;

   string_escape_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic rsp_payload_type plain_char(input logic [7:0] c);
      rsp_payload_type r;
      r.out_char = c;
      r.out_last = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return (nib < 4'd10) ? "0" + 8'(nib) : "a" + 8'(nib) - 8'd10;
   endfunction

   // expected characters for one accepted transaction
   function automatic void encode_item(input req_payload_type item, input logic [1:0] fmt);
      rsp_payload_type chars[$];
      logic            opening;
      logic            closing;
      logic [7:0]      esc;
      opening = item.first_byte | item.empty_string;
      closing = item.last_byte | item.empty_string;
      esc = 8'h00;
      case (fmt)
         FMT_HEX: begin
            if (!item.empty_string) begin
               chars.push_back(plain_char(hex_digit(item.data_byte[7:4])));
               chars.push_back(plain_char(hex_digit(item.data_byte[3:0])));
            end
         end
         FMT_SQL: begin
            if (opening)
               for (int i = 0; i < sql_open.len(); i++) chars.push_back(plain_char(sql_open[i]));
            if (!item.empty_string) begin
               chars.push_back(plain_char(hex_digit(item.data_byte[7:4])));
               chars.push_back(plain_char(hex_digit(item.data_byte[3:0])));
            end
            if (closing)
               for (int i = 0; i < sql_close.len(); i++) chars.push_back(plain_char(sql_close[i]));
         end
         FMT_QUOTE: begin
            if (opening) chars.push_back(plain_char(CHAR_QUOTE));
            if (!item.empty_string) begin
               case (item.data_byte)
                  CHAR_BEL:       esc = "a";
                  CHAR_BS:        esc = "b";
                  CHAR_FF:        esc = "f";
                  CHAR_LF:        esc = "n";
                  CHAR_CR:        esc = "r";
                  CHAR_TAB:       esc = "t";
                  CHAR_VT:        esc = "v";
                  CHAR_BACKSLASH: esc = CHAR_BACKSLASH;
                  CHAR_QUOTE:     esc = CHAR_QUOTE;
                  default:        esc = 8'h00;
               endcase
               if (esc != 8'h00) begin
                  chars.push_back(plain_char(CHAR_BACKSLASH));
                  chars.push_back(plain_char(esc));
               end else begin
                  chars.push_back(plain_char(item.data_byte));
               end
            end
            if (closing) chars.push_back(plain_char(CHAR_QUOTE));
         end
         default: ;
      endcase
      if (chars.size() > 0) chars[chars.size() - 1].out_last = 1'b1;
      foreach (chars[i]) expected_chars.push_back(chars[i]);
   endfunction

   function automatic req_payload_type make_item(input logic [7:0] b, input logic f,
                                                 input logic l, input logic e);
      req_payload_type it;
      it.data_byte    = b;
      it.first_byte   = f;
      it.last_byte    = l;
      it.empty_string = e;
      return it;
   endfunction

   // bytes biased toward escapes and the extremes
   function automatic logic [7:0] random_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0, 1:    b = escape_bytes[$urandom_range(0, 8)];
         2:       b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
         default: b = 8'($urandom());
      endcase
      return b;
   endfunction

   // mostly well-formed strings, some empty strings and flag noise
   task automatic add_random_strings(input int count);
      int made;
      int len;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_reqs.push_back(make_item(random_byte(), 1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1))));
            made++;
         end else if ($urandom_range(0, 9) == 0) begin
            pending_reqs.push_back(make_item(random_byte(), 1'($urandom_range(0, 1)),
                                             1'($urandom_range(0, 1)), 1'b1));
            made++;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               pending_reqs.push_back(make_item(random_byte(), i == 0, i == len - 1, 1'b0));
            made += len;
         end
      end
   endtask

   // block idle: everything sent, everything received, plus a settle margin
   task automatic wait_idle();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_format(input logic [1:0] fmt);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      predicted_format = fmt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // driver: bursts of transactions from the pending queue with random gaps
   always @(posedge clock) begin : driver
      logic            offer;
      req_payload_type next_item;
      offer = req_valid;
      next_item = req_payload;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_item(req_payload, predicted_format);
            offer = 1'b0;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               offer = 1'b1;
               next_item = pending_reqs.pop_front();
            end
         end
      end
      req_valid   <= offer;
      req_payload <= next_item;
   end

   // receiver: rotating stall pattern, plus long hold-offs to back up the input
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done < 2 && results_seen >= next_hold_at &&
                   pending_reqs.size() >= HOLD_MIN_QUEUE) begin
         hold_left = HOLD_CYCLES - 1;
         holds_done++;
         next_hold_at += 1200;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern = '1;
               1:       stall_pattern = $urandom();
               2:       stall_pattern = $urandom() | $urandom();
               default: stall_pattern = $urandom() & $urandom();
            endcase
            pattern_age = 48;
         end
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
         rsp_ready <= stall_pattern[0];
      end
   end

   // monitor: compare each received character with the oldest expectation
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_chars.size() == 0) begin
            report_error($sformatf("unexpected character 0x%02h last=%0b",
                                   rsp_payload.out_char, rsp_payload.out_last));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.out_char !== want.out_char)
               report_error($sformatf("out_char got 0x%02h want 0x%02h",
                                      rsp_payload.out_char, want.out_char));
            if (rsp_payload.out_last !== want.out_last)
               report_error($sformatf("out_last got %0b want %0b on char 0x%02h",
                                      rsp_payload.out_last, want.out_last, want.out_char));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, expected_chars.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // hex digits: zero byte, all-ones byte, empty string gives nothing
      set_format(FMT_HEX);
      pending_reqs.push_back(make_item(8'h00, 1'b1, 1'b1, 1'b0));
      pending_reqs.push_back(make_item(8'hFF, 1'b0, 1'b0, 1'b0));
      pending_reqs.push_back(make_item(8'hA5, 1'b1, 1'b0, 1'b1));
      wait_idle();

      // sql wrapper: prefix and suffix on one byte, split string, empty string
      set_format(FMT_SQL);
      pending_reqs.push_back(make_item(8'hFF, 1'b1, 1'b1, 1'b0));
      pending_reqs.push_back(make_item(8'h00, 1'b1, 1'b0, 1'b0));
      pending_reqs.push_back(make_item(8'h5A, 1'b0, 1'b0, 1'b0));
      pending_reqs.push_back(make_item(8'h3C, 1'b0, 1'b1, 1'b0));
      pending_reqs.push_back(make_item(8'h00, 1'b0, 1'b0, 1'b1));
      wait_idle();

      // quoted string: every escape, pass-through extremes, empty string
      set_format(FMT_QUOTE);
      foreach (escape_bytes[i])
         pending_reqs.push_back(make_item(escape_bytes[i], i == 0, 1'b0, 1'b0));
      pending_reqs.push_back(make_item(8'h00, 1'b0, 1'b0, 1'b0));
      pending_reqs.push_back(make_item(8'hFF, 1'b0, 1'b0, 1'b0));
      pending_reqs.push_back(make_item("A", 1'b0, 1'b1, 1'b0));
      pending_reqs.push_back(make_item(8'h7E, 1'b0, 1'b1, 1'b1));
      pending_reqs.push_back(make_item(CHAR_QUOTE, 1'b1, 1'b1, 1'b0));
      wait_idle();

      // unused format value: transactions are dropped
      set_format(FMT_UNUSED);
      pending_reqs.push_back(make_item(8'h41, 1'b1, 1'b1, 1'b0));
      pending_reqs.push_back(make_item(8'h00, 1'b0, 1'b0, 1'b1));
      wait_idle();

      // random phases, format changed only with the block drained
      foreach (phase_formats[p]) begin
         set_format(phase_formats[p]);
         add_random_strings((phase_formats[p] == FMT_UNUSED) ? 16 : 32);
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (expected_chars.size() != 0)
         report_error($sformatf("%0d characters never received", expected_chars.size()));
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/see_pkg.sv
rtl/see_gen.sv
rtl/string_escape_encoder.sv
dv/testbench.sv
